@@ hdl/mwf_pkg.sv @@
// Shared widths, reset values, parameter defaults and register indexes of the median filter.
package mwf_pkg;

    localparam int PIXEL_W        = 8;
    localparam int ROW_W          = 16;
    localparam int COL_W          = 10;
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 16;
    localparam int CFG_DATA_W     = 16;

    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;

    localparam int DEF_WIN_W      = 3;
    localparam int DEF_WIN_H      = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

@@ hdl/mwf_pixel_if.sv @@
// Input pixel channel with valid and ready.
interface mwf_pixel_if;
    import mwf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

@@ hdl/mwf_result_if.sv @@
// Result channel carrying the median, its position and the end of frame flag.
interface mwf_result_if;
    import mwf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] median;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               frame_done;

    modport source (output valid, output median, output out_row, output out_col,
                    output frame_done, input ready);
    modport sink (input valid, input median, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

@@ hdl/mwf_line_store.sv @@
// Line buffers holding the column history of the previous rows, with registered reads.
module mwf_line_store #(
    parameter int DEPTH = 1024,
    parameter int NLB   = 2,
    parameter int PB    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [$clog2(DEPTH)-1:0] i_col,
    input  logic [PB-1:0]            i_pix,
    output logic [PB-1:0]            o_hist [NLB]
);
    import mwf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [PB-1:0] r_hist [NLB];
    logic          r_wpend;
    logic [AW-1:0] r_wcol;

    // Each buffer below the first is written in the cycle after the read, so a read of the
    // same column in that cycle takes the pending data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_wcol <= i_col;
        end
    end

    for (genvar k = 0; k < NLB; k++) begin : g_lb
        logic [PB-1:0] r_mem [DEPTH];

        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_hist[0]     <= r_mem[i_col];
                    r_mem[i_col]  <= i_pix;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (r_wpend) begin
                    r_mem[r_wcol] <= r_hist[k-1];
                end
                if (i_load) begin
                    if (r_wpend && (r_wcol == i_col)) begin
                        r_hist[k] <= r_hist[k-1];
                    end else begin
                        r_hist[k] <= r_mem[i_col];
                    end
                end
            end
        end
    end

    assign o_hist = r_hist;

endmodule

@@ hdl/mwf_median.sv @@
// Rank selection network returning the element at the middle index of the sorted window.
module mwf_median #(
    parameter int N  = 9,
    parameter int PB = 8
) (
    input  logic [PB-1:0] i_win [N],
    output logic [PB-1:0] o_med
);
    import mwf_pkg::*;

    localparam int RW = $clog2(N + 1);
    localparam logic [RW-1:0] MID = RW'(N / 2);

    // Ties are broken by position, so every element gets a distinct rank.
    always_comb begin
        logic [RW-1:0] rank;
        o_med = '0;
        for (int i = 0; i < N; i++) begin
            rank = '0;
            for (int j = 0; j < N; j++) begin
                if ((i_win[j] < i_win[i]) || ((i_win[j] == i_win[i]) && (j < i))) begin
                    rank = rank + RW'(1);
                end
            end
            if (rank == MID) begin
                o_med = o_med | i_win[i];
            end
        end
    end

endmodule

@@ hdl/median_window_image_filter.sv @@
// Streaming 2D median filter over a window of the latest image rows.
//
//   Channel   Direction  Transaction carries
//   i_pix     in         pixel (one grey pixel in raster order)
//   o_res     out        median, out_row, out_col, frame_done
//   i_cfg_*   in         register index and write data
//
// One pixel is taken every cycle while i_pix.ready is high. A result passes through
// the line store read register, the window register and the result register.
// Reset clears the row and column counters and loads width 640 and height 480;
// the line stores are not cleared. Back pressure on o_res fills the three stages
// before i_pix.ready falls. Pixels without a result leave the pipeline silently.
module median_window_image_filter #(
    parameter int WIN_W      = mwf_pkg::DEF_WIN_W,
    parameter int WIN_H      = mwf_pkg::DEF_WIN_H,
    parameter int MAX_WIDTH  = mwf_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = mwf_pkg::DEF_PIXEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mwf_pixel_if.sink                         i_pix,
    mwf_result_if.source                      o_res,
    input  logic                              i_cfg_we,
    input  mwf_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [mwf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mwf_pkg::*;

    localparam int HALF_W = WIN_W / 2;
    localparam int HALF_H = WIN_H / 2;
    localparam int NLB    = 2 * HALF_H;
    localparam int NLB_E  = (NLB > 0) ? NLB : 1;
    localparam int HIST   = NLB + 1;
    localparam int NCOL   = 2 * HALF_W + 1;
    localparam int WIN_N  = WIN_W * WIN_H;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int EW     = (WIDTH_REG_W > $clog2(MAX_WIDTH + 1)) ?
                            WIDTH_REG_W : $clog2(MAX_WIDTH + 1);

    typedef struct packed {
        logic             emit;
        logic             medok;
        logic             last;
        logic [ROW_W-1:0] orow;
        logic [COL_W-1:0] ocol;
    } t_meta;

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [AW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    logic [AW-1:0]           n_col;
    logic [ROW_W-1:0]        n_row;
    logic [EW-1:0]           w_ext;
    logic [AW-1:0]           w_last_col;
    logic [ROW_W-1:0]        w_last_row;

    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    t_meta                   r_m1;
    t_meta                   r_m2;
    t_meta                   n_m1;
    logic [PIXEL_BITS-1:0]   r_pix1;
    logic [PIXEL_BITS-1:0]   w_pix;
    logic [PIXEL_BITS-1:0]   w_hist [NLB_E];
    logic [PIXEL_BITS-1:0]   w_column [HIST];
    logic [PIXEL_BITS-1:0]   r_win [NCOL][HIST];
    logic [PIXEL_BITS-1:0]   w_elem [WIN_N];
    logic [PIXEL_BITS-1:0]   w_med;
    logic [PIXEL_W-1:0]      r_med3;
    logic [ROW_W-1:0]        r_orow3;
    logic [COL_W-1:0]        r_ocol3;
    logic                    r_last3;

    logic                    s1_free;
    logic                    s2_free;
    logic                    s3_free;
    logic                    in_acc;
    logic                    s1_to_s2;
    logic                    s2_to_s3;

    assign s3_free  = !r_v3 || o_res.ready;
    assign s2_free  = !r_v2 || !r_m2.emit || s3_free;
    assign s1_free  = !r_v1 || s2_free;
    assign in_acc   = i_pix.valid && s1_free;
    assign s1_to_s2 = r_v1 && s2_free;
    assign s2_to_s3 = r_v2 && r_m2.emit && s3_free;

    assign i_pix.ready = s1_free;
    assign w_pix       = PIXEL_BITS'(i_pix.pixel);

    // Width zero acts as one and widths above the line store depth are clamped.
    always_comb begin
        w_ext = EW'(r_width);
        if (w_ext == '0) begin
            w_last_col = '0;
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_last_col = AW'(MAX_WIDTH - 1);
        end else begin
            w_last_col = AW'(w_ext - EW'(1));
        end
        w_last_row = (r_height == '0) ? '0 : ROW_W'(r_height - HEIGHT_REG_W'(1));
    end

    always_comb begin
        n_col = r_col + AW'(1);
        n_row = r_row;
        if (r_col == w_last_col) begin
            n_col = '0;
            n_row = (r_row == w_last_row) ? '0 : r_row + ROW_W'(1);
        end
    end

    always_comb begin
        n_m1.emit  = (r_row >= ROW_W'(HALF_H)) && (r_col >= AW'(HALF_W));
        n_m1.medok = (r_row >= ROW_W'(2 * HALF_H)) && (r_col >= AW'(2 * HALF_W));
        n_m1.last  = (r_row == w_last_row) && (r_col == w_last_col);
        n_m1.orow  = r_row - ROW_W'(HALF_H);
        n_m1.ocol  = COL_W'(r_col - AW'(HALF_W));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_REG_W'(WIDTH_RESET);
            r_height <= HEIGHT_REG_W'(HEIGHT_RESET);
            r_col    <= '0;
            r_row    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else begin
            r_v1 <= in_acc || (r_v1 && !s2_free);
            r_v2 <= s1_to_s2 || (r_v2 && !s2_free);
            r_v3 <= s2_to_s3 || (r_v3 && !o_res.ready);
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH: begin
                        r_width <= WIDTH_REG_W'(i_cfg_data);
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= HEIGHT_REG_W'(i_cfg_data);
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    mwf_line_store #(
        .DEPTH (MAX_WIDTH),
        .NLB   (NLB_E),
        .PB    (PIXEL_BITS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_col   (r_col),
        .i_pix   (w_pix),
        .o_hist  (w_hist)
    );

    always_comb begin
        w_column[0] = r_pix1;
        for (int k = 1; k < HIST; k++) begin
            w_column[k] = w_hist[k-1];
        end
    end

    always_comb begin
        for (int n = 0; n < WIN_H; n++) begin
            for (int m = 0; m < WIN_W; m++) begin
                w_elem[n * WIN_W + m] = r_win[m][2 * HALF_H - n];
            end
        end
    end

    mwf_median #(
        .N  (WIN_N),
        .PB (PIXEL_BITS)
    ) u_median (
        .i_win (w_elem),
        .o_med (w_med)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_m1   <= n_m1;
            r_pix1 <= w_pix;
        end
        if (s1_to_s2) begin
            r_m2 <= r_m1;
            for (int j = 0; j < NCOL - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[NCOL-1] <= w_column;
        end
        if (s2_to_s3) begin
            r_med3  <= r_m2.medok ? PIXEL_W'(w_med) : '0;
            r_orow3 <= r_m2.orow;
            r_ocol3 <= r_m2.ocol;
            r_last3 <= r_m2.last;
        end
    end

    assign o_res.valid      = r_v3;
    assign o_res.median     = r_med3;
    assign o_res.out_row    = r_orow3;
    assign o_res.out_col    = r_ocol3;
    assign o_res.frame_done = r_last3;

endmodule

@@ hdl/mwf_checker.sv @@
// Port level assertions for the median filter and their binding to the top level.
module mwf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mwf_pkg::PIXEL_W-1:0] i_median,
    input logic [mwf_pkg::ROW_W-1:0]  i_out_row,
    input logic [mwf_pkg::COL_W-1:0]  i_out_col,
    input logic                       i_frame_done
);
    import mwf_pkg::*;

    logic             out_acc;
    logic             r_have_prev;
    logic             r_prev_done;
    logic [ROW_W-1:0] r_prev_row;
    logic [COL_W-1:0] r_prev_col;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (out_acc) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev_done <= i_frame_done;
            r_prev_row  <= i_out_row;
            r_prev_col  <= i_out_col;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_median) &&
        $stable(i_out_row) && $stable(i_out_col) && $stable(i_frame_done))
        else $error("stalled result changed");

    a_col_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have_prev && !r_prev_done |->
        (i_out_col == r_prev_col + COL_W'(1)) || (i_out_col == '0))
        else $error("result column skipped");

    a_row_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have_prev && (i_out_col != '0) |-> i_out_row == r_prev_row)
        else $error("result row changed within a row");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have_prev && r_prev_done |-> (i_out_row == '0) && (i_out_col == '0))
        else $error("frame did not restart at the origin");

endmodule

bind median_window_image_filter mwf_checker u_mwf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_median     (o_res.median),
    .i_out_row    (o_res.out_row),
    .i_out_col    (o_res.out_col),
    .i_frame_done (o_res.frame_done)
);

@@ tb/tb_top.sv @@
// Testbench of the median filter: random frames, sizes and stalls, checked by a scoreboard.
module tb_top;
    import mwf_pkg::*;

    localparam int HALF_W       = DEF_WIN_W / 2;
    localparam int HALF_H       = DEF_WIN_H / 2;
    localparam int HIST_ROWS    = 2 * HALF_H + 1;
    localparam int WIN_N        = DEF_WIN_W * DEF_WIN_H;
    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 365;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [PIXEL_W-1:0] median;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               frame_done;
    } t_median_result;

    class median_scoreboard;
        logic [PIXEL_W-1:0]      col_hist [DEF_MAX_WIDTH][HIST_ROWS];
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        int                      next_row;
        int                      next_col;
        t_median_result          median_q[$];
        int                      bad_results;

        function new();
            width_reg   = WIDTH_REG_W'(WIDTH_RESET);
            height_reg  = HEIGHT_REG_W'(HEIGHT_RESET);
            next_row    = 0;
            next_col    = 0;
            bad_results = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = data[WIDTH_REG_W-1:0];
            end else begin
                height_reg = data[HEIGHT_REG_W-1:0];
            end
            next_row = 0;
            next_col = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int eff_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function int pending();
            return median_q.size();
        endfunction

        function logic [PIXEL_W-1:0] window_median(int c);
            logic [PIXEL_W-1:0] vals [WIN_N];
            logic [PIXEL_W-1:0] v;
            int                 k;
            int                 j;
            k = 0;
            for (int n = 0; n < DEF_WIN_H; n++) begin
                for (int m = 0; m < DEF_WIN_W; m++) begin
                    vals[k] = col_hist[c - 2 * HALF_W + m][2 * HALF_H - n];
                    k++;
                end
            end
            for (int i = 1; i < WIN_N; i++) begin
                v = vals[i];
                j = i - 1;
                while (j >= 0 && vals[j] > v) begin
                    vals[j + 1] = vals[j];
                    j--;
                end
                vals[j + 1] = v;
            end
            return vals[WIN_N / 2];
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] pix);
            int             w;
            int             h;
            int             r;
            int             c;
            t_median_result res;
            w = eff_width();
            h = eff_height();
            if (next_col >= w) begin
                next_col = 0;
                next_row++;
            end
            if (next_row >= h) next_row = 0;
            r = next_row;
            c = next_col;
            for (int k = HIST_ROWS - 1; k > 0; k--) col_hist[c][k] = col_hist[c][k - 1];
            col_hist[c][0] = pix;
            if (r >= HALF_H && c >= HALF_W) begin
                res.median     = (r >= 2 * HALF_H && c >= 2 * HALF_W) ? window_median(c) : '0;
                res.row        = ROW_W'(r - HALF_H);
                res.col        = COL_W'(c - HALF_W);
                res.frame_done = (r == h - 1) && (c == w - 1);
                median_q.push_back(res);
            end
            next_col = c + 1;
            if (next_col >= w) begin
                next_col = 0;
                next_row = r + 1;
                if (next_row >= h) next_row = 0;
            end
        endfunction

        function void check_result(t_median_result got);
            t_median_result want;
            if (median_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("Unexpected result: median %0d row %0d col %0d done %0b",
                             got.median, got.row, got.col, got.frame_done);
                end
                return;
            end
            want = median_q.pop_front();
            if (got.median !== want.median || got.row !== want.row ||
                got.col !== want.col || got.frame_done !== want.frame_done) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display({"Mismatch: expected median %0d row %0d col %0d done %0b,",
                              " got %0d %0d %0d %0b"},
                             want.median, want.row, want.col, want.frame_done,
                             got.median, got.row, got.col, got.frame_done);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit                    idle_en = 1'b1;
    int                    cycle_count = 0;
    median_scoreboard      sb = new();

    mwf_pixel_if  pix_if ();
    mwf_result_if res_if ();

    median_window_image_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int             stall;
        t_median_result got;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.median     = res_if.median;
                got.row        = res_if.out_row;
                got.col        = res_if.out_col;
                got.frame_done = res_if.frame_done;
                sb.check_result(got);
            end
            if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 11) == 0) begin
                stall = $urandom_range(1, 14) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(logic [PIXEL_W-1:0] value);
        int gap;
        if (idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note_pixel(value);
    endtask

    task automatic stop_pixels();
        pix_if.valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [PIXEL_W-1:0] rand_pixel(int mode);
        case (mode)
            0: return PIXEL_W'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return PIXEL_W'($urandom_range(120, 127));
            default: return $urandom_range(0, 3) == 0 ? 8'h00 : PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random(int count, int mode);
        for (int i = 0; i < count; i++) send_pixel(rand_pixel(mode));
        stop_pixels();
    endtask

    initial begin
        logic [PIXEL_W-1:0]    checker_px [9];
        logic [PIXEL_W-1:0]    walk_px [9];
        int                    sent;
        int                    count;
        int                    area;
        int                    sel;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;

        checker_px = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        walk_px    = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE};
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_IMAGE_WIDTH;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset size is seen only once the second row starts.
        send_random(643, 0);
        drain();

        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        foreach (checker_px[i]) send_pixel(checker_px[i]);
        stop_pixels();
        wait_results();
        foreach (checker_px[i]) send_pixel(~checker_px[i]);
        for (int i = 0; i < 4; i++) send_pixel(checker_px[i]);
        stop_pixels();
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        foreach (walk_px[i]) send_pixel(walk_px[i]);
        stop_pixels();
        drain();

        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        send_random(3, 0);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        send_random(8, 1);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - 200) idle_en = 1'b0;
            case ($urandom_range(0, 9))
                0:       wdata = 16'd0;
                1:       wdata = CFG_DATA_W'($urandom_range(1, 2));
                9:       wdata = CFG_DATA_W'($urandom_range(13, 40));
                default: wdata = CFG_DATA_W'($urandom_range(3, 12));
            endcase
            if ($urandom_range(0, 19) == 0) wdata = CFG_DATA_W'($urandom_range(1025, 2047));
            if ($urandom_range(0, 3) == 0) begin
                wdata[CFG_DATA_W-1:WIDTH_REG_W] = (CFG_DATA_W - WIDTH_REG_W)'($urandom);
            end
            case ($urandom_range(0, 9))
                0:       hdata = 16'd0;
                1:       hdata = CFG_DATA_W'($urandom_range(1, 2));
                9:       hdata = CFG_DATA_W'($urandom_range(9, 65535));
                default: hdata = CFG_DATA_W'($urandom_range(3, 8));
            endcase
            sel = $urandom_range(0, 2);
            if (sel != 1) write_reg(CFG_IMAGE_WIDTH, wdata);
            if (sel != 0) write_reg(CFG_IMAGE_HEIGHT, hdata);
            area  = sb.eff_width() * sb.eff_height();
            count = area * $urandom_range(1, 2) + $urandom_range(0, area);
            if (count > 160) count = $urandom_range(40, 160);
            send_random(count, $urandom_range(0, 3));
            drain();
            sent += count;
        end

        wait_results();
        repeat (SETTLE * 2) @(posedge i_clk);
        if (sb.bad_results == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mwf_pkg.sv
hdl/mwf_pixel_if.sv
hdl/mwf_result_if.sv
hdl/mwf_line_store.sv
hdl/mwf_median.sv
hdl/median_window_image_filter.sv
hdl/mwf_checker.sv
tb/tb_top.sv
